FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker in acc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given reset is low.
`define ACC_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Same, on the usual clk and arst_n of the enclosing module.
`define ACC_ASSERT_CLK(lbl, prop, msg) \
	`ACC_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

FILE: rtl/acc_pkg.sv
package acc_pkg;

	// Event kinds carried in the mode field of an input transaction.
	localparam logic [1:0] KIND_SECOND = 2'd0;
	localparam logic [1:0] KIND_MS     = 2'd1;
	localparam logic [1:0] KIND_LOAD   = 2'd2;

	// Key codes.
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_SET  = 3'd1;
	localparam logic [2:0] KEY_ALM  = 3'd2;
	localparam logic [2:0] KEY_UP   = 3'd3;
	localparam logic [2:0] KEY_DOWN = 3'd4;
	localparam logic [2:0] KEY_FAST = 3'd5;

	// Operating modes.
	localparam logic [2:0] MODE_NORMAL   = 3'd0;
	localparam logic [2:0] MODE_EDIT_HR  = 3'd1;
	localparam logic [2:0] MODE_EDIT_MIN = 3'd2;
	localparam logic [2:0] MODE_ALM_HR   = 3'd3;
	localparam logic [2:0] MODE_ALM_MIN  = 3'd4;

	// Alarm store handshake phases.
	localparam logic [1:0] SAVE_IDLE  = 2'd0;
	localparam logic [1:0] SAVE_ISSUE = 2'd1;
	localparam logic [1:0] SAVE_WAIT  = 2'd2;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;
	localparam logic [CFG_INDEX_W-1:0] CFG_RING_LEN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BEEP_LEN  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TMO  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAST_FACT = 2'd3;

	localparam logic [12:0] RING_LEN_RST  = 13'd5000;
	localparam logic [12:0] BEEP_LEN_RST  = 13'd300;
	localparam logic [7:0]  IDLE_TMO_RST  = 8'd30;
	localparam logic [7:0]  FAST_FACT_RST = 8'd200;

	// Time and pattern limits.
	localparam logic [4:0] HOUR_MAX     = 5'd23;
	localparam logic [5:0] MINUTE_MAX   = 6'd59;
	localparam logic [9:0] BLINK_HALF   = 10'd500;
	localparam logic [9:0] PIP_ON_LEN   = 10'd500;
	localparam logic [9:0] PIP_PERIOD   = 10'd1000;

	typedef struct packed {
		logic [12:0] ring_len;
		logic [12:0] beep_len;
		logic [7:0]  idle_timeout;
		logic [7:0]  fast_factor;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] key_code;
		logic       store_ready;
		logic [7:0] load_hour;
		logic [7:0] load_minute;
	} in_item_t;

	typedef struct packed {
		logic [4:0] display_hour;
		logic [5:0] display_minute;
		logic       blank_hour_digits;
		logic       blank_minute_digits;
		logic       led_on;
		logic       buzzer_drive;
		logic       store_request;
		logic [4:0] store_hour;
		logic [5:0] store_minute;
		logic       fast_time;
		logic [2:0] edit_mode;
	} out_item_t;

endpackage

FILE: rtl/acc_in_if.sv
interface acc_in_if import acc_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/acc_out_if.sv
interface acc_out_if import acc_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

FILE: rtl/acc_cfg.sv
module acc_cfg import acc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ring_len     <= RING_LEN_RST;
			cfg_q.beep_len     <= BEEP_LEN_RST;
			cfg_q.idle_timeout <= IDLE_TMO_RST;
			cfg_q.fast_factor  <= FAST_FACT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RING_LEN:  cfg_q.ring_len     <= cfg_wdata;
				CFG_BEEP_LEN:  cfg_q.beep_len     <= cfg_wdata;
				CFG_IDLE_TMO:  cfg_q.idle_timeout <= cfg_wdata[7:0];
				CFG_FAST_FACT: cfg_q.fast_factor  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/acc_core.sv
module acc_core import acc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	typedef struct packed {
		logic [4:0]  time_hour;
		logic [5:0]  time_minute;
		logic [5:0]  time_second;
		logic [4:0]  edit_hour;
		logic [5:0]  edit_minute;
		logic        edit_changed;
		logic [4:0]  alm_hour;
		logic [5:0]  alm_minute;
		logic [2:0]  mode;
		logic [15:0] idle_count;
		logic [8:0]  blink_count;
		logic        blink_phase;
		logic [12:0] ring_count;
		logic [9:0]  pip_count;
		logic        buzzer;
		logic [1:0]  save_phase;
		logic        fast_flag;
	} clk_state_t;

	clk_state_t st_q;
	clk_state_t nx;
	logic        req;
	logic [15:0] idle_load;
	logic [15:0] idle_dec;
	logic [9:0]  pip_inc;
	logic [9:0]  blink_inc;
	logic        edit_mode_act;
	logic        alm_mode_act;

	assign idle_load = 16'(cfg.idle_timeout) *
		16'(st_q.fast_flag ? cfg.fast_factor : 8'd1);
	assign edit_mode_act = (st_q.mode == MODE_EDIT_HR) || (st_q.mode == MODE_EDIT_MIN);
	assign alm_mode_act  = (st_q.mode == MODE_ALM_HR) || (st_q.mode == MODE_ALM_MIN);
	assign pip_inc   = st_q.pip_count + 10'd1;
	assign blink_inc = {1'b0, st_q.blink_count} + 10'd1;
	assign idle_dec  = (st_q.idle_count != 16'd0) ? st_q.idle_count - 16'd1 : 16'd0;

	always_comb begin
		nx  = st_q;
		req = 1'b0;
		case (item.mode)
			KIND_SECOND: begin
				if (st_q.time_second >= MINUTE_MAX) begin
					nx.time_second = 6'd0;
					if (st_q.time_minute >= MINUTE_MAX) begin
						nx.time_minute = 6'd0;
						nx.time_hour = (st_q.time_hour >= HOUR_MAX) ? 5'd0 :
							st_q.time_hour + 5'd1;
					end else begin
						nx.time_minute = st_q.time_minute + 6'd1;
					end
					if (nx.time_hour == st_q.alm_hour && nx.time_minute == st_q.alm_minute &&
							st_q.ring_count == 13'd0) begin
						nx.ring_count = cfg.ring_len;
						nx.pip_count  = 10'd0;
					end
				end else begin
					nx.time_second = st_q.time_second + 6'd1;
				end
				// Idle auto-exit out of any time or alarm edit mode, with a short beep.
				if (st_q.mode != MODE_NORMAL) begin
					nx.idle_count = idle_dec;
					if (idle_dec == 16'd0) begin
						if (edit_mode_act && st_q.edit_changed) begin
							nx.time_hour   = st_q.edit_hour;
							nx.time_minute = st_q.edit_minute;
							nx.time_second = 6'd0;
						end
						if (alm_mode_act) begin
							nx.save_phase = SAVE_ISSUE;
						end
						nx.mode        = MODE_NORMAL;
						nx.blink_phase = 1'b1;
						nx.blink_count = 9'd0;
						nx.ring_count  = cfg.beep_len;
						nx.pip_count   = 10'd0;
					end
				end
			end
			KIND_MS: begin
				// Buzzer pattern: on for the first half of each second while ringing.
				if (st_q.ring_count != 13'd0) begin
					nx.ring_count = st_q.ring_count - 13'd1;
					nx.pip_count  = pip_inc;
					if (pip_inc < PIP_ON_LEN) begin
						nx.buzzer = 1'b1;
					end else if (pip_inc < PIP_PERIOD) begin
						nx.buzzer = 1'b0;
					end else begin
						nx.pip_count = 10'd0;
					end
					if (nx.ring_count == 13'd0) begin
						nx.buzzer    = 1'b0;
						nx.pip_count = 10'd0;
					end
				end
				case (st_q.save_phase)
					SAVE_ISSUE: begin
						if (item.store_ready) begin
							req = 1'b1;
							nx.save_phase = SAVE_WAIT;
						end
					end
					SAVE_WAIT: begin
						if (item.store_ready) begin
							nx.save_phase = SAVE_IDLE;
						end
					end
					default: ;
				endcase
				if (blink_inc >= BLINK_HALF) begin
					nx.blink_count = 9'd0;
					nx.blink_phase = ~st_q.blink_phase;
				end else begin
					nx.blink_count = blink_inc[8:0];
				end
				if (item.key_code != KEY_NONE) begin
					nx.idle_count = idle_load;
				end
				case (item.key_code)
					KEY_SET: begin
						nx.ring_count = cfg.beep_len;
						nx.pip_count  = 10'd0;
						if (st_q.mode == MODE_NORMAL) begin
							nx.mode         = MODE_EDIT_HR;
							nx.edit_hour    = st_q.time_hour;
							nx.edit_minute  = st_q.time_minute;
							nx.edit_changed = 1'b0;
						end else if (st_q.mode == MODE_EDIT_HR) begin
							nx.mode = MODE_EDIT_MIN;
						end else begin
							// A stale edit flag also commits when leaving an alarm mode.
							nx.mode = MODE_NORMAL;
							if (st_q.edit_changed) begin
								nx.time_hour   = st_q.edit_hour;
								nx.time_minute = st_q.edit_minute;
								nx.time_second = 6'd0;
							end
						end
						nx.blink_phase = 1'b1;
						nx.blink_count = 9'd0;
					end
					KEY_ALM: begin
						nx.ring_count = cfg.beep_len;
						nx.pip_count  = 10'd0;
						if (edit_mode_act && st_q.edit_changed) begin
							nx.time_hour   = st_q.edit_hour;
							nx.time_minute = st_q.edit_minute;
							nx.time_second = 6'd0;
						end
						if (st_q.mode == MODE_NORMAL) begin
							nx.mode = MODE_ALM_HR;
						end else if (st_q.mode == MODE_ALM_HR) begin
							nx.mode = MODE_ALM_MIN;
						end else begin
							nx.mode       = MODE_NORMAL;
							nx.save_phase = SAVE_ISSUE;
						end
						nx.blink_phase = 1'b1;
						nx.blink_count = 9'd0;
					end
					KEY_UP: begin
						nx.ring_count = cfg.beep_len;
						nx.pip_count  = 10'd0;
						case (st_q.mode)
							MODE_EDIT_HR: begin
								nx.edit_hour = (st_q.edit_hour >= HOUR_MAX) ? 5'd0 :
									st_q.edit_hour + 5'd1;
								nx.edit_changed = 1'b1;
							end
							MODE_EDIT_MIN: begin
								nx.edit_minute = (st_q.edit_minute >= MINUTE_MAX) ? 6'd0 :
									st_q.edit_minute + 6'd1;
								nx.edit_changed = 1'b1;
							end
							MODE_ALM_HR: begin
								nx.alm_hour = (st_q.alm_hour >= HOUR_MAX) ? 5'd0 :
									st_q.alm_hour + 5'd1;
							end
							MODE_ALM_MIN: begin
								nx.alm_minute = (st_q.alm_minute >= MINUTE_MAX) ? 6'd0 :
									st_q.alm_minute + 6'd1;
							end
							default: ;
						endcase
						nx.blink_phase = 1'b1;
						nx.blink_count = 9'd0;
					end
					KEY_DOWN: begin
						nx.ring_count = cfg.beep_len;
						nx.pip_count  = 10'd0;
						case (st_q.mode)
							MODE_EDIT_HR: begin
								nx.edit_hour = (st_q.edit_hour == 5'd0) ? HOUR_MAX :
									st_q.edit_hour - 5'd1;
								nx.edit_changed = 1'b1;
							end
							MODE_EDIT_MIN: begin
								nx.edit_minute = (st_q.edit_minute == 6'd0) ? MINUTE_MAX :
									st_q.edit_minute - 6'd1;
								nx.edit_changed = 1'b1;
							end
							MODE_ALM_HR: begin
								nx.alm_hour = (st_q.alm_hour == 5'd0) ? HOUR_MAX :
									st_q.alm_hour - 5'd1;
							end
							MODE_ALM_MIN: begin
								nx.alm_minute = (st_q.alm_minute == 6'd0) ? MINUTE_MAX :
									st_q.alm_minute - 6'd1;
							end
							default: ;
						endcase
						nx.blink_phase = 1'b1;
						nx.blink_count = 9'd0;
					end
					KEY_FAST: begin
						nx.ring_count = cfg.beep_len;
						nx.pip_count  = 10'd0;
						nx.fast_flag  = ~st_q.fast_flag;
					end
					default: ;
				endcase
			end
			KIND_LOAD: begin
				nx.alm_hour   = (item.load_hour > 8'(HOUR_MAX)) ? 5'd0 : item.load_hour[4:0];
				nx.alm_minute = (item.load_minute > 8'(MINUTE_MAX)) ? 6'd0 :
					item.load_minute[5:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{blink_phase: 1'b1, default: '0};
		end else if (step) begin
			st_q <= nx;
		end
	end

	always_comb begin
		if (nx.mode == MODE_ALM_HR || nx.mode == MODE_ALM_MIN) begin
			result.display_hour   = nx.alm_hour;
			result.display_minute = nx.alm_minute;
		end else if (nx.mode == MODE_EDIT_HR || nx.mode == MODE_EDIT_MIN) begin
			result.display_hour   = nx.edit_hour;
			result.display_minute = nx.edit_minute;
		end else begin
			result.display_hour   = nx.time_hour;
			result.display_minute = nx.time_minute;
		end
		result.blank_hour_digits   = (nx.mode == MODE_EDIT_HR || nx.mode == MODE_ALM_HR) &&
			!nx.blink_phase;
		result.blank_minute_digits = (nx.mode == MODE_EDIT_MIN || nx.mode == MODE_ALM_MIN) &&
			!nx.blink_phase;
		result.led_on       = (nx.mode == MODE_ALM_HR || nx.mode == MODE_ALM_MIN) &&
			nx.blink_phase;
		result.buzzer_drive = nx.buzzer;
		result.store_request = req;
		// A store write carries the alarm as it stood before this transaction's key.
		result.store_hour    = req ? st_q.alm_hour : nx.alm_hour;
		result.store_minute  = req ? st_q.alm_minute : nx.alm_minute;
		result.fast_time     = nx.fast_flag;
		result.edit_mode     = nx.mode;
	end

endmodule

FILE: rtl/alarm_clock_controller.sv
// 24-hour alarm clock controller. Each input transaction is one event: a one-second tick,
// a millisecond tick carrying a key code and the store-ready bit, or a load of the stored
// alarm. Every event yields exactly one result transaction with the displayed time, digit
// blanking, LED, buzzer level, the alarm store request and the current mode. The block
// takes one transaction per clock unless back-pressure holds it: the event is captured
// in an input register, and the whole clock, mode, buzzer and blink update is
// combinational logic from that register into the result register, with the clock
// state written at the same edge. Back-pressure on the result side stalls the input
// register, and input ready drops only when both registers are full and the result is not
// being taken. The user must write configuration registers through the write port only
// while no events are in flight; the block itself does not enforce this.
module alarm_clock_controller import acc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	acc_in_if.sink                 in_ch,
	acc_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t      cfg;
	logic      in_valid_s1;
	in_item_t  in_item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	out_item_t result;
	logic      advance;

	acc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance     = in_valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			in_valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			in_item_s1 <= in_ch.item;
		end
	end

	acc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (in_item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item_q <= result;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_item_q;

endmodule

FILE: rtl/acc_checker.sv
`include "assert_macros.svh"

module acc_checker import acc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// A stalled result must stay in place.
	`ACC_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_item)), "result changed while stalled")

	// After a store write is issued the handshake waits, so the next result cannot ask again.
	`ACC_ASSERT_CLK(a_store_once, (out_valid && out_ready && out_item.store_request) |=> !(out_valid && out_item.store_request), "store request repeated")

	`ACC_ASSERT_CLK(a_time_range, out_valid |-> (out_item.display_hour <= HOUR_MAX && out_item.display_minute <= MINUTE_MAX && out_item.store_hour <= HOUR_MAX && out_item.store_minute <= MINUTE_MAX), "time value out of range")

	`ACC_ASSERT_CLK(a_led_mode, (out_valid && (out_item.led_on || out_item.blank_hour_digits || out_item.blank_minute_digits)) |-> (out_item.edit_mode != MODE_NORMAL), "blink output in normal mode")

endmodule

bind alarm_clock_controller acc_checker u_acc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_item  (out_ch.item)
);
